// ===== rtl/bounded_deque_with_search_assert.svh =====
// Assertion macros shared by the deque modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and controller/datapath types for the bounded
// deque with value search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int RDSEL_W     = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONTAINS   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    // Store read address select
    localparam logic [RDSEL_W-1:0] RD_HEAD     = 2'd0;
    localparam logic [RDSEL_W-1:0] RD_BACK     = 2'd1;
    localparam logic [RDSEL_W-1:0] RD_IDX      = 2'd2;
    localparam logic [RDSEL_W-1:0] RD_IDX_NEXT = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                apply;
        logic                st_wr;
        logic [STATUS_W-1:0] st_code;
        logic                idx_clr;
        logic                idx_inc;
        logic                rd_en;
        logic [RDSEL_W-1:0]  rd_sel;
        logic                shift_wr;
        logic                cnt_dec;
        logic                cap_front;
        logic                emit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              match;
        logic              idx_last;
        logic              shift_last;
    } t_dp_stat;

    // Ring position: head plus offset, wrapped at DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Ring store, head and count registers, scan index and result registers.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_assert.svh"

module bdq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [bdq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [bdq_pkg::OUT_W-1:0]    i_item_value,
    input  bdq_pkg::t_dp_cmd                    i_cmd,
    output bdq_pkg::t_dp_stat                   o_stat,
    output logic                                o_result_valid,
    output logic [bdq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [bdq_pkg::OUT_W-1:0]    o_front_value,
    output logic signed [bdq_pkg::OUT_W-1:0]    o_back_value,
    output logic [bdq_pkg::CNT_W-1:0]           o_held_count,
    output logic                                o_is_empty
);

    logic [bdq_pkg::VALUE_WIDTH-1:0] r_mem [bdq_pkg::DEPTH];
    logic [bdq_pkg::VALUE_WIDTH-1:0] r_rdata;
    logic [bdq_pkg::VALUE_WIDTH-1:0] r_front;
    logic [bdq_pkg::VALUE_WIDTH-1:0] r_value;
    logic [bdq_pkg::MODE_W-1:0]      r_mode;
    logic [bdq_pkg::IDX_W-1:0]       r_head, n_head;
    logic [bdq_pkg::CNT_W-1:0]       r_count, n_count;
    logic [bdq_pkg::IDX_W-1:0]       r_idx;
    logic [bdq_pkg::STATUS_W-1:0]    r_status;

    logic                            r_out_valid;
    logic [bdq_pkg::STATUS_W-1:0]    r_out_status;
    logic [bdq_pkg::OUT_W-1:0]       r_out_front;
    logic [bdq_pkg::OUT_W-1:0]       r_out_back;
    logic [bdq_pkg::CNT_W-1:0]       r_out_count;
    logic                            r_out_empty;

    logic                            wr_en;
    logic [bdq_pkg::IDX_W-1:0]       wr_addr;
    logic [bdq_pkg::VALUE_WIDTH-1:0] wr_data;
    logic [bdq_pkg::IDX_W-1:0]       rd_off;
    logic [bdq_pkg::IDX_W-1:0]       rd_addr;
    logic [bdq_pkg::IDX_W-1:0]       idx_next;
    logic [bdq_pkg::IDX_W-1:0]       cnt_low;
    logic [bdq_pkg::IDX_W-1:0]       back_off;
    logic [bdq_pkg::CNT_W:0]         idx_plus1;
    logic [bdq_pkg::CNT_W:0]         idx_plus2;
    logic                            cnt_zero;

    assign cnt_zero  = (r_count == '0);
    assign cnt_low   = r_count[bdq_pkg::IDX_W-1:0];
    assign back_off  = cnt_low - bdq_pkg::IDX_W'(1);
    assign idx_next  = r_idx + bdq_pkg::IDX_W'(1);
    assign idx_plus1 = (bdq_pkg::CNT_W+1)'(r_idx) + (bdq_pkg::CNT_W+1)'(1);
    assign idx_plus2 = (bdq_pkg::CNT_W+1)'(r_idx) + (bdq_pkg::CNT_W+1)'(2);

    // Status toward the controller
    assign o_stat.mode       = r_mode;
    assign o_stat.full       = (r_count >= bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign o_stat.empty      = cnt_zero;
    assign o_stat.match      = (r_rdata == r_value);
    assign o_stat.idx_last   = (idx_plus1 >= (bdq_pkg::CNT_W+1)'(r_count));
    assign o_stat.shift_last = (idx_plus2 >= (bdq_pkg::CNT_W+1)'(r_count));

    // Edit head and count, pick the store write
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        wr_en   = 1'b0;
        wr_addr = bdq_pkg::ring_add(r_head, r_idx);
        wr_data = r_rdata;
        if (i_cmd.apply) begin
            case (r_mode)
                bdq_pkg::MODE_PUSH_FRONT: begin
                    n_head  = (r_head == '0) ? bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1)
                                             : r_head - bdq_pkg::IDX_W'(1);
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = n_head;
                    wr_data = r_value;
                end
                bdq_pkg::MODE_PUSH_BACK: begin
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = bdq_pkg::ring_add(r_head, cnt_low);
                    wr_data = r_value;
                end
                bdq_pkg::MODE_POP_FRONT: begin
                    n_head  = bdq_pkg::ring_add(r_head, bdq_pkg::IDX_W'(1));
                    n_count = r_count - bdq_pkg::CNT_W'(1);
                end
                bdq_pkg::MODE_POP_BACK: begin
                    n_count = r_count - bdq_pkg::CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.shift_wr) begin
            wr_en = 1'b1;
        end
        if (i_cmd.cnt_dec) begin
            n_count = r_count - bdq_pkg::CNT_W'(1);
        end
    end

    // Select the read offset from the front
    always_comb begin
        unique case (i_cmd.rd_sel)
            bdq_pkg::RD_HEAD:     rd_off = '0;
            bdq_pkg::RD_BACK:     rd_off = back_off;
            bdq_pkg::RD_IDX:      rd_off = r_idx;
            bdq_pkg::RD_IDX_NEXT: rd_off = idx_next;
            default:              rd_off = '0;
        endcase
    end
    assign rd_addr = bdq_pkg::ring_add(r_head, rd_off);

    // Ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= i_cmd.emit;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_next;
            end
        end
    end

    // Latch the request word, status and front value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_item_value[bdq_pkg::VALUE_WIDTH-1:0];
        end
        if (i_cmd.st_wr) begin
            r_status <= i_cmd.st_code;
        end
        if (i_cmd.cap_front) begin
            r_front <= r_rdata;
        end
    end

    // Result word registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_front  <= cnt_zero ? '0 : bdq_pkg::OUT_W'(r_front);
            r_out_back   <= cnt_zero ? '0 : bdq_pkg::OUT_W'(r_rdata);
            r_out_count  <= r_count;
            r_out_empty  <= cnt_zero;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_held_count   = r_out_count;
    assign o_is_empty     = r_out_empty;

    `BDQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH), "count above depth")
    `BDQ_ASSERT_NOW(a_no_write_clash, i_cmd.apply, !i_cmd.shift_wr && !i_cmd.cnt_dec, "edit clash")

endmodule

// ===== rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer for one request: edit, scan, close the gap, read the ends, emit.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_search_assert.svh"

module bdq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bdq_pkg::t_dp_stat  i_stat,
    output bdq_pkg::t_dp_cmd   o_cmd,
    output logic               busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCMP = 3'd3;
    localparam logic [2:0] S_MRD  = 3'd4;
    localparam logic [2:0] S_MWR  = 3'd5;
    localparam logic [2:0] S_RDF  = 3'd6;
    localparam logic [2:0] S_RDB  = 3'd7;
    localparam logic [2:0] S_OUT  = 3'd0;

    logic [2:0] r_state, n_state;
    logic       r_emit, n_emit;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_emit  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start && !r_emit) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.st_wr = 1'b1;
                n_state     = S_RDF;
                case (i_stat.mode) inside
                    bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK: begin
                        o_cmd.st_code = i_stat.full ? bdq_pkg::ST_FULL : bdq_pkg::ST_OK;
                        o_cmd.apply   = !i_stat.full;
                    end
                    bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_BACK: begin
                        o_cmd.st_code = i_stat.empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
                        o_cmd.apply   = !i_stat.empty;
                    end
                    bdq_pkg::MODE_CONTAINS, bdq_pkg::MODE_REMOVE: begin
                        o_cmd.st_code = bdq_pkg::ST_ABSENT;
                        o_cmd.idx_clr = 1'b1;
                        if (!i_stat.empty) begin
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        o_cmd.st_code = bdq_pkg::ST_OK;
                    end
                endcase
            end
            S_SRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bdq_pkg::RD_IDX;
                n_state      = S_SCMP;
            end
            S_SCMP: begin
                if (i_stat.match) begin
                    o_cmd.st_wr   = 1'b1;
                    o_cmd.st_code = bdq_pkg::ST_OK;
                    if (i_stat.mode == bdq_pkg::MODE_REMOVE) begin
                        if (i_stat.idx_last) begin
                            o_cmd.cnt_dec = 1'b1;
                            n_state       = S_RDF;
                        end else begin
                            n_state = S_MRD;
                        end
                    end else begin
                        n_state = S_RDF;
                    end
                end else if (i_stat.idx_last) begin
                    n_state = S_RDF;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_MRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bdq_pkg::RD_IDX_NEXT;
                n_state      = S_MWR;
            end
            S_MWR: begin
                o_cmd.shift_wr = 1'b1;
                if (i_stat.shift_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RDF;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_MRD;
                end
            end
            S_RDF: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bdq_pkg::RD_HEAD;
                n_state      = S_RDB;
            end
            S_RDB: begin
                o_cmd.cap_front = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = bdq_pkg::RD_BACK;
                n_state         = S_IDLE;
                n_emit          = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Final result cycle: back value is in the read register now
        if (r_emit) begin
            o_cmd.emit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    // The output step shares the idle code, so hold busy through it
    assign busy = (r_state != S_IDLE) || r_emit;

    `BDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after accept")
    `BDQ_ASSERT_NEXT(a_emit_idle, r_emit, r_state == S_OUT && !r_emit, "emit not followed by idle")
    `BDQ_ASSERT_NOW(a_shift_remove, o_cmd.shift_wr, i_stat.mode == bdq_pkg::MODE_REMOVE,
                    "gap close outside remove")

endmodule

// ===== rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed words with search and remove-by-value.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Its result word
// appears on the o_ ports for exactly one cycle, marked by o_result_valid, and
// cannot be held off; busy drops in that same cycle, so the next request may
// be taken there. Pushes, pops and unknown modes go through the edit, front
// read and back read steps before the result is emitted. Contains compares
// entries from the front until one matches or the last one is compared;
// remove scans the same way and then moves every entry behind the match one
// place toward the front to close the gap. The scan and the gap close are
// paced by the ring store's one registered read port: every compare and
// every entry moved to close the gap costs one read step and one compare
// or write step.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bdq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [bdq_pkg::OUT_W-1:0]    i_item_value,
    output logic                                o_result_valid,
    output logic [bdq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [bdq_pkg::OUT_W-1:0]    o_front_value,
    output logic signed [bdq_pkg::OUT_W-1:0]    o_back_value,
    output logic [bdq_pkg::CNT_W-1:0]           o_held_count,
    output logic                                o_is_empty
);

    bdq_pkg::t_dp_cmd  dp_cmd;
    bdq_pkg::t_dp_stat dp_stat;

    // Sequencer
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // Store and result registers
    bdq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_item_value   (i_item_value),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_held_count   (o_held_count),
        .o_is_empty     (o_is_empty)
    );

endmodule
